>>> hw/rtl/fxexp_pkg.sv
// Shared widths, codes and inter-stage structs for the exponential table interpolator.
package fxexp_pkg;

   localparam int VALUE_W    = 24;
   localparam int STEP_W     = 12;
   localparam int COUNT_W    = 9;
   localparam int SAMPLE_W   = 16;
   localparam int INDEX_W    = 8;
   localparam int PROD_W     = SAMPLE_W + STEP_W;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   // Register indexes on the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_TOP_VALUE   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_SIZE   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENTRY_COUNT = 2'd2;

   // Beat kinds carried on req_tuser
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_EVAL  = 1'b1;

   // Sideband that rides along the index divider
   typedef struct packed {
      logic                       kind;
      logic [INDEX_W-1:0]         entry_index;
      logic signed [SAMPLE_W-1:0] entry_data;
      logic                       neg;
   } front_side_type;

   // Table write request at the memory stage
   typedef struct packed {
      logic                       write;
      logic [INDEX_W-1:0]         index;
      logic signed [SAMPLE_W-1:0] data;
   } tbl_wr_type;

   // Sideband that rides along the interpolation divider
   typedef struct packed {
      logic                       neg_diff;
      logic signed [SAMPLE_W-1:0] base;
   } back_side_type;

endpackage

>>> hw/rtl/fxexp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage, with sideband.
module fxexp_div_pipe #(
   parameter int QUOT_W    = 24,
   parameter int DIVISOR_W = 12,
   parameter int SIDE_W    = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [DIVISOR_W-1:0] in_rem,    // upper dividend bits, below divisor
   input  logic [QUOT_W-1:0]    in_work,   // lower dividend bits
   input  logic [SIDE_W-1:0]    in_side,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 out_valid,
   output logic [QUOT_W-1:0]    out_quot,
   output logic [DIVISOR_W-1:0] out_rem,
   output logic [SIDE_W-1:0]    out_side
);

   logic                 valid_ff [QUOT_W];
   logic [DIVISOR_W-1:0] rem_ff   [QUOT_W];
   logic [DIVISOR_W-1:0] rem_in   [QUOT_W];
   logic [QUOT_W-1:0]    work_ff  [QUOT_W];
   logic [QUOT_W-1:0]    work_in  [QUOT_W];
   logic [SIDE_W-1:0]    side_ff  [QUOT_W];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_step
      logic                 src_valid;
      logic [DIVISOR_W-1:0] src_rem;
      logic [QUOT_W-1:0]    src_work;
      logic [SIDE_W-1:0]    src_side;
      logic [DIVISOR_W:0]   trial;
      logic [DIVISOR_W:0]   trial_sub;
      logic                 ge;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_rem;
         assign src_work  = in_work;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_work  = work_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      // shift in the next dividend bit, subtract when it fits
      assign trial     = {src_rem, src_work[QUOT_W-1]};
      assign ge        = (trial >= {1'b0, divisor});
      assign trial_sub = trial - {1'b0, divisor};
      assign rem_in[k]  = ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      assign work_in[k] = {src_work[QUOT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            work_ff[k] <= work_in[k];
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign out_quot  = work_ff[QUOT_W-1];
   assign out_rem   = rem_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

>>> hw/rtl/fxexp_table.sv
// Sample table memory: one write port, two registered read ports.
module fxexp_table #(
   parameter  int DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  fxexp_pkg::tbl_wr_type                 wr,
   input  logic [ADDR_W-1:0]                     rd_addr0,
   input  logic [ADDR_W-1:0]                     rd_addr1,
   output logic signed [fxexp_pkg::SAMPLE_W-1:0] rd_data0,
   output logic signed [fxexp_pkg::SAMPLE_W-1:0] rd_data1
);

   logic signed [fxexp_pkg::SAMPLE_W-1:0] sample_mem_ff [DEPTH];
   logic signed [fxexp_pkg::SAMPLE_W-1:0] rd_data0_ff;
   logic signed [fxexp_pkg::SAMPLE_W-1:0] rd_data1_ff;
   logic                                  wr_in_range;

   // drop writes past the end of the table
   assign wr_in_range = (32'(wr.index) < 32'(DEPTH));

   always_ff @(posedge clock) begin
      if (en && wr.write && wr_in_range) begin
         sample_mem_ff[ADDR_W'(wr.index)] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_data0_ff <= sample_mem_ff[rd_addr0];
         rd_data1_ff <= sample_mem_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

>>> hw/rtl/fixed_exp_table_interp.sv
// Fixed-point exp by table lookup and linear interpolation. The block takes one beat per
// cycle while its skid buffer is empty. An evaluate beat passes through these registers in
// order: the offset from top_value, 24 stages of the bit-serial index divider, the table
// addresses, the two-port table read, the neighbor difference, the multiply, 16 stages of
// the interpolation divider and the output register.
// Table-write beats travel the same pipeline and update the table at the read stage, so
// evaluates see every write accepted before them; they produce no response. A stalled
// response side fills a one-beat skid buffer, and the pipeline holds while it is full.
// Configuration must be written only while no beat is in flight; the block doesn't enforce it.
module fixed_exp_table_interp #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [fxexp_pkg::REQ_DATA_W-1:0]        req_tdata,  // entry_index, entry_data, value
   input  logic                                    req_tuser,  // kind
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [fxexp_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // result
   input  logic                                    csr_we,
   input  logic [fxexp_pkg::CSR_ADDR_W-1:0]        csr_index,
   input  logic [fxexp_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int VW    = fxexp_pkg::VALUE_W;
   localparam int SW    = fxexp_pkg::SAMPLE_W;
   localparam int STW   = fxexp_pkg::STEP_W;
   localparam int CW    = fxexp_pkg::COUNT_W;
   localparam int PW    = fxexp_pkg::PROD_W;

   // ---------------- configuration registers
   logic signed [VW-1:0] top_value_ff, top_value_in;
   logic [STW-1:0]       step_size_ff, step_size_in;
   logic [CW-1:0]        entry_count_ff, entry_count_in;
   logic [STW-1:0]       step_eff;
   logic [IDX_W-1:0]     last_idx;

   always_comb begin
      top_value_in   = top_value_ff;
      step_size_in   = step_size_ff;
      entry_count_in = entry_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            fxexp_pkg::CSR_TOP_VALUE:   top_value_in   = csr_wdata[VW-1:0];
            fxexp_pkg::CSR_STEP_SIZE:   step_size_in   = csr_wdata[STW-1:0];
            fxexp_pkg::CSR_ENTRY_COUNT: entry_count_in = csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_value_ff   <= '0;
         step_size_ff   <= STW'(30);
         entry_count_ff <= CW'(239);
      end else begin
         top_value_ff   <= top_value_in;
         step_size_ff   <= step_size_in;
         entry_count_ff <= entry_count_in;
      end
   end

   // a zero step acts as one; the count is held to 1..TABLE_DEPTH
   assign step_eff = (step_size_ff == '0) ? STW'(1) : step_size_ff;

   always_comb begin
      if (entry_count_ff == '0) begin
         last_idx = '0;
      end else if (32'(entry_count_ff) > 32'(TABLE_DEPTH)) begin
         last_idx = IDX_W'(TABLE_DEPTH - 1);
      end else begin
         last_idx = IDX_W'(entry_count_ff - 1'b1);
      end
   end

   // ---------------- pipeline advance
   logic skid_valid_ff, skid_valid_in;
   logic en;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // ---------------- stage A: offset from the top of the table
   logic signed [VW:0]        offset;
   logic                      a_valid_ff;
   logic [VW-1:0]             a_mag_ff, a_mag_in;
   fxexp_pkg::front_side_type a_side_ff, a_side_in;

   assign offset = {top_value_ff[VW-1], top_value_ff}
                 - {req_tdata[47], req_tdata[47:24]};

   always_comb begin
      a_side_in.kind        = req_tuser;
      a_side_in.entry_index = req_tdata[7:0];
      a_side_in.entry_data  = req_tdata[23:8];
      a_side_in.neg         = offset[VW];
      a_mag_in              = offset[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mag_ff  <= a_mag_in;
         a_side_ff <= a_side_in;
      end
   end

   // ---------------- index divider
   logic                      d1_valid;
   logic [VW-1:0]             d1_quot;
   logic [STW-1:0]            d1_rem;
   fxexp_pkg::front_side_type d1_side;

   fxexp_div_pipe #(
      .QUOT_W    (VW),
      .DIVISOR_W (STW),
      .SIDE_W    ($bits(fxexp_pkg::front_side_type))
   ) u_index_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_valid_ff),
      .in_rem    ('0),
      .in_work   (a_mag_ff),
      .in_side   (a_side_ff),
      .divisor   (step_eff),
      .out_valid (d1_valid),
      .out_quot  (d1_quot),
      .out_rem   (d1_rem),
      .out_side  (d1_side)
   );

   // ---------------- stage B: clamp and table addresses
   fxexp_pkg::tbl_wr_type b_wr_ff, b_wr_in;
   logic                  b_eval_ff, b_eval_in;
   logic [IDX_W-1:0]      b_addr0_ff, b_addr0_in;
   logic [IDX_W-1:0]      b_addr1_ff, b_addr1_in;
   logic [STW-1:0]        b_rem_ff, b_rem_in;

   always_comb begin
      b_wr_in.write = d1_valid && (d1_side.kind == fxexp_pkg::KIND_WRITE);
      b_wr_in.index = d1_side.entry_index;
      b_wr_in.data  = d1_side.entry_data;
      b_eval_in     = d1_valid && (d1_side.kind == fxexp_pkg::KIND_EVAL);
      if (d1_side.neg) begin
         b_addr0_in = '0;
         b_rem_in   = '0;
      end else if (d1_quot >= VW'(last_idx)) begin
         b_addr0_in = last_idx;
         b_rem_in   = '0;
      end else begin
         b_addr0_in = d1_quot[IDX_W-1:0];
         b_rem_in   = d1_rem;
      end
      b_addr1_in = b_addr0_in + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_wr_ff.write <= 1'b0;
         b_eval_ff     <= 1'b0;
      end else if (en) begin
         b_wr_ff.write <= b_wr_in.write;
         b_eval_ff     <= b_eval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_wr_ff.index <= b_wr_in.index;
         b_wr_ff.data  <= b_wr_in.data;
         b_addr0_ff    <= b_addr0_in;
         b_addr1_ff    <= b_addr1_in;
         b_rem_ff      <= b_rem_in;
      end
   end

   // ---------------- stage C: table access
   logic signed [SW-1:0] t0;
   logic signed [SW-1:0] t1;
   logic                 c_valid_ff;
   logic [STW-1:0]       c_rem_ff;

   fxexp_table #(
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock    (clock),
      .en       (en),
      .wr       (b_wr_ff),
      .rd_addr0 (b_addr0_ff),
      .rd_addr1 (b_addr1_ff),
      .rd_data0 (t0),
      .rd_data1 (t1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_eval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_rem_ff <= b_rem_ff;
      end
   end

   // ---------------- stage D: neighbor difference as sign and magnitude
   logic signed [SW:0]   diff;
   logic [SW:0]          diff_abs;
   logic                 d_valid_ff;
   logic                 d_neg_ff, d_neg_in;
   logic [SW-1:0]        d_mag_ff, d_mag_in;
   logic [STW-1:0]       d_rem_ff;
   logic signed [SW-1:0] d_base_ff;

   always_comb begin
      // exact samples never look at the upper neighbor
      if (c_rem_ff == '0) begin
         diff = '0;
      end else begin
         diff = {t1[SW-1], t1} - {t0[SW-1], t0};
      end
      d_neg_in = diff[SW];
      diff_abs = d_neg_in ? -diff : diff;
      d_mag_in = diff_abs[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_neg_ff  <= d_neg_in;
         d_mag_ff  <= d_mag_in;
         d_rem_ff  <= c_rem_ff;
         d_base_ff <= t0;
      end
   end

   // ---------------- stage E: difference times fraction
   logic                     e_valid_ff;
   logic [PW-1:0]            e_prod_ff, e_prod_in;
   fxexp_pkg::back_side_type e_side_ff, e_side_in;

   always_comb begin
      e_prod_in          = {{STW{1'b0}}, d_mag_ff} * {{SW{1'b0}}, d_rem_ff};
      e_side_in.neg_diff = d_neg_ff;
      e_side_in.base     = d_base_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_prod_ff <= e_prod_in;
         e_side_ff <= e_side_in;
      end
   end

   // ---------------- interpolation divider: quotient stays below 2^16
   logic                     d2_valid;
   logic [SW-1:0]            d2_quot;
   fxexp_pkg::back_side_type d2_side;

   fxexp_div_pipe #(
      .QUOT_W    (SW),
      .DIVISOR_W (STW),
      .SIDE_W    ($bits(fxexp_pkg::back_side_type))
   ) u_interp_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_valid_ff),
      .in_rem    (e_prod_ff[PW-1:SW]),
      .in_work   (e_prod_ff[SW-1:0]),
      .in_side   (e_side_ff),
      .divisor   (step_eff),
      .out_valid (d2_valid),
      .out_quot  (d2_quot),
      .out_rem   (),
      .out_side  (d2_side)
   );

   // ---------------- final sum, output register and skid buffer
   logic [SW:0]   delta;
   logic [SW:0]   sum;
   logic [SW-1:0] result;
   logic          out_valid_ff, out_valid_in;
   logic [SW-1:0] out_data_ff, out_data_in;
   logic [SW-1:0] skid_data_ff, skid_data_in;
   logic          out_free;

   assign delta  = d2_side.neg_diff ? -{1'b0, d2_quot} : {1'b0, d2_quot};
   assign sum    = {d2_side.base[SW-1], d2_side.base} + delta;
   assign result = sum[SW-1:0];

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = d2_valid;
            out_data_in  = result;
         end
      end else if (d2_valid && en) begin
         // hold the new beat while the response side stalls
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

>>> hw/rtl/fxexp_checker.sv
// Port-level checks for the exponential table interpolator, bound to the top level.
module fxexp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [fxexp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input logic                                 req_tuser,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [fxexp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                 csr_we,
   input logic [fxexp_pkg::CSR_ADDR_W-1:0]     csr_index,
   input logic [fxexp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // a stalled response beat stays
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response beat dropped while stalled");

   // a stalled response beat keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response payload changed while stalled");

   // reset empties the output side and opens the input
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output or skid not cleared by reset");

   // input backpressure only follows a stalled response beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && $past(rsp_tvalid && !rsp_tready))
      else $error("input stalled without a stalled response");

endmodule

bind fixed_exp_table_interp fxexp_checker u_fxexp_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fixed_exp_table_interp: table loads, probes, random evaluates.
module tb;

   localparam int DEPTH     = 256;
   localparam int DRAIN_PAD = 64;   // covers the pipeline with margin
   localparam int HOLD_LEN  = 400;
   localparam int N_PROBES  = 18;

   typedef struct packed {
      logic                                   kind;
      logic [fxexp_pkg::INDEX_W-1:0]          idx;
      logic signed [fxexp_pkg::SAMPLE_W-1:0]  data;
      logic signed [fxexp_pkg::VALUE_W-1:0]   arg;
      logic                                   typed;
      logic [fxexp_pkg::RSP_DATA_W-1:0]       result;
   } probe_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [fxexp_pkg::REQ_DATA_W-1:0]    req_tdata;
   logic                                req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [fxexp_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                                csr_we;
   logic [fxexp_pkg::CSR_ADDR_W-1:0]    csr_index;
   logic [fxexp_pkg::CSR_DATA_W-1:0]    csr_wdata;

   // Shadow of the block's table and registers
   logic signed [fxexp_pkg::SAMPLE_W-1:0] sample_mem [DEPTH];
   logic signed [fxexp_pkg::VALUE_W-1:0]  top_value_q   = '0;
   logic [fxexp_pkg::STEP_W-1:0]          step_size_q   = 12'd30;
   logic [fxexp_pkg::COUNT_W-1:0]         entry_count_q = 9'd239;

   logic [fxexp_pkg::RSP_DATA_W-1:0] results_due [$];
   int                               error_count  = 0;
   bit                               quiet        = 1'b0;
   bit                               hold_request = 1'b0;
   probe_row_type                    probe_rows [N_PROBES];

   fixed_exp_table_interp uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // entry_index, entry_data, value
      .req_tuser  (req_tuser),    // kind
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // result
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [fxexp_pkg::RSP_DATA_W-1:0] interp_exp(
         input logic signed [fxexp_pkg::VALUE_W-1:0] arg);
      int step;
      int count;
      int offset;
      int idx;
      int base;
      int lo;
      int hi;
      step  = (step_size_q == 0) ? 1 : int'(step_size_q);
      count = int'(entry_count_q);
      if (count < 1) count = 1;
      if (count > DEPTH) count = DEPTH;
      offset = int'(top_value_q) - int'(arg);
      idx    = offset / step;
      if (idx >= count - 1) return sample_mem[count - 1];
      if (idx < 0) return sample_mem[0];
      base = idx * step;
      lo   = sample_mem[idx];
      if (offset > base) begin
         hi = sample_mem[idx + 1];
         return fxexp_pkg::RSP_DATA_W'(lo + ((hi - lo) * (offset - base)) / step);
      end
      return fxexp_pkg::RSP_DATA_W'(lo);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Offer one beat, then track its effect once accepted
   task automatic send_beat(input logic kind, input logic [fxexp_pkg::INDEX_W-1:0] idx,
                            input logic [fxexp_pkg::SAMPLE_W-1:0] data,
                            input logic [fxexp_pkg::VALUE_W-1:0] arg,
                            input logic typed,
                            input logic [fxexp_pkg::RSP_DATA_W-1:0] typed_result);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {arg, data, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == fxexp_pkg::KIND_WRITE)
         sample_mem[idx] = data;
      else
         results_due.push_back(typed ? typed_result : interp_exp(arg));
   endtask

   // Drain every pending result, then let trailing table writes clear the pipe
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_csr(input logic [fxexp_pkg::CSR_ADDR_W-1:0] index, input int data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= fxexp_pkg::CSR_DATA_W'(data);
      @(posedge clock);
      case (index)
         fxexp_pkg::CSR_TOP_VALUE:   top_value_q   = data[fxexp_pkg::VALUE_W-1:0];
         fxexp_pkg::CSR_STEP_SIZE:   step_size_q   = data[fxexp_pkg::STEP_W-1:0];
         fxexp_pkg::CSR_ENTRY_COUNT: entry_count_q = data[fxexp_pkg::COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int top, input int step, input int count);
      write_csr(fxexp_pkg::CSR_TOP_VALUE, top);
      write_csr(fxexp_pkg::CSR_STEP_SIZE, step);
      write_csr(fxexp_pkg::CSR_ENTRY_COUNT, count);
      csr_we <= 1'b0;
   endtask

   // Mostly arguments that land inside the table span, plus raw values and table writes
   task automatic run_phase(input int n);
      int step;
      int count;
      int off;
      int pick;
      logic [fxexp_pkg::VALUE_W-1:0] arg;
      for (int k = 0; k < n; k++) begin
         step  = (step_size_q == 0) ? 1 : int'(step_size_q);
         count = int'(entry_count_q);
         if (count < 1) count = 1;
         if (count > DEPTH) count = DEPTH;
         arg  = fxexp_pkg::VALUE_W'($urandom);
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            send_beat(fxexp_pkg::KIND_WRITE, fxexp_pkg::INDEX_W'($urandom),
                      fxexp_pkg::SAMPLE_W'($urandom), arg, 1'b0, '0);
         end else begin
            if (pick >= 8) begin
               off = int'($urandom_range(0, count * step + 2 * step)) - step;
               arg = fxexp_pkg::VALUE_W'(int'(top_value_q) - off);
            end else if (pick >= 6) begin
               off = step * int'($urandom_range(0, count));
               arg = fxexp_pkg::VALUE_W'(int'(top_value_q) - off);
            end
            send_beat(fxexp_pkg::KIND_EVAL, fxexp_pkg::INDEX_W'($urandom),
                      fxexp_pkg::SAMPLE_W'($urandom), arg, 1'b0, '0);
         end
      end
   endtask

   always @(posedge clock) begin
      logic [fxexp_pkg::RSP_DATA_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", rsp_tdata));
         end else begin
            want = results_due.pop_front();
            if (rsp_tdata !== want)
               report_mismatch($sformatf("result %h, expected %h", rsp_tdata, want));
         end
      end
   end

   // Receiver: random stall bursts, one long hold on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = fxexp_pkg::KIND_WRITE;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = fxexp_pkg::CSR_TOP_VALUE;
      csr_wdata  = '0;

      probe_rows = '{
         '{fxexp_pkg::KIND_WRITE, 8'd0,   16'sd32767,  24'sd0,       1'b0, 16'h0000},
         '{fxexp_pkg::KIND_WRITE, 8'd1,   16'sh8000,   24'sd0,       1'b0, 16'h0000},
         '{fxexp_pkg::KIND_WRITE, 8'd238, 16'sd1234,   24'sd0,       1'b0, 16'h0000},
         '{fxexp_pkg::KIND_WRITE, 8'd255, -16'sd1,     24'sd0,       1'b0, 16'h0000},
         '{fxexp_pkg::KIND_EVAL,  8'd0,   16'sd0,      24'sd0,       1'b1, 16'h7FFF}, // exact top
         '{fxexp_pkg::KIND_EVAL,  8'd0,   16'sd0,      24'sd30,      1'b1, 16'h7FFF}, // neg index
         '{fxexp_pkg::KIND_EVAL,  8'd0,   16'sd0,      24'sd1,       1'b1, 16'h7FFF}, // just below
         '{fxexp_pkg::KIND_EVAL,  8'd0,   16'sd0,     -24'sd30,      1'b1, 16'h8000}, // exact
         '{fxexp_pkg::KIND_EVAL,  8'hA5,  16'sd77,    -24'sd15,      1'b0, 16'h0000},
         '{fxexp_pkg::KIND_EVAL,  8'd0,   16'sd0,     -24'sd29,      1'b0, 16'h0000},
         '{fxexp_pkg::KIND_EVAL,  8'd0,   16'sd0,      24'sh800000,  1'b1, 16'd1234}, // past end
         '{fxexp_pkg::KIND_EVAL,  8'd0,   16'sd0,      24'sd8388607, 1'b1, 16'h7FFF}, // above top
         '{fxexp_pkg::KIND_EVAL,  8'd0,   16'sd0,     -24'sd7110,    1'b0, 16'h0000},
         '{fxexp_pkg::KIND_EVAL,  8'd0,   16'sd0,     -24'sd7139,    1'b0, 16'h0000},
         '{fxexp_pkg::KIND_EVAL,  8'd0,   16'sd0,     -24'sd7140,    1'b1, 16'd1234}, // last
         '{fxexp_pkg::KIND_WRITE, 8'd0,   16'sd100,   -24'sd1,       1'b0, 16'h0000},
         '{fxexp_pkg::KIND_EVAL,  8'd0,   16'sd0,      24'sd0,       1'b1, 16'd100},  // new data
         '{fxexp_pkg::KIND_EVAL,  8'hFF, -16'sd1,     -24'sd1,       1'b0, 16'h0000}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole table so no evaluate ever reads an unwritten entry
      for (int i = 0; i < DEPTH; i++)
         send_beat(fxexp_pkg::KIND_WRITE, fxexp_pkg::INDEX_W'(i),
                   fxexp_pkg::SAMPLE_W'($urandom), fxexp_pkg::VALUE_W'($urandom), 1'b0, '0);

      for (int i = 0; i < N_PROBES; i++)
         send_beat(probe_rows[i].kind, probe_rows[i].idx, probe_rows[i].data,
                   probe_rows[i].arg, probe_rows[i].typed, probe_rows[i].result);
      wait_idle();

      set_config(0, 1, 1);
      run_phase(120);
      wait_idle();

      set_config(-8388608, 4095, 256);
      hold_request = 1'b1;
      run_phase(200);
      wait_idle();

      // zero step and zero count fall back to one
      set_config(8388607, 0, 0);
      run_phase(120);
      wait_idle();

      set_config(int'($urandom), int'($urandom_range(1, 4095)), 511);
      run_phase(200);
      wait_idle();

      set_config(int'($urandom), int'($urandom_range(1, 64)), int'($urandom_range(2, 256)));
      run_phase(220);
      wait_idle();

      quiet = 1'b1;
      set_config(int'($urandom), int'($urandom_range(1, 300)), int'($urandom_range(2, 256)));
      run_phase(220);
      wait_idle();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
